// ===== hw/rtl/view_cone_visibility_gate_unit_assert.svh =====
// assertion macros for the view cone visibility gate
`ifndef VIEW_CONE_VISIBILITY_GATE_UNIT_ASSERT_SVH
`define VIEW_CONE_VISIBILITY_GATE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define VCG_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("vcg check failed");
`define VCG_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("vcg check failed");
`else
`define VCG_ASSERT(lbl, clk, rstn, prop)
`define VCG_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== hw/rtl/vcg_pkg.sv =====
// shared types, codes and tables of the view cone visibility gate
package vcg_pkg;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TIMER, ST_MAC, ST_MAC_END, ST_TEST,
    ST_GO_P, ST_WAIT_P, ST_GO_Q, ST_WAIT_Q, ST_FIN
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_SQX, OP_SQY, OP_SQZ, OP_SQR,
    OP_DOTX, OP_DOTY, OP_DOTZ, OP_SR, OP_CC
  } mul_op_e;

  typedef enum logic [1:0] {
    FIN_OFF, FIN_NOCHECK, FIN_PASS, FIN_FAIL
  } fin_e;

  typedef struct packed {
    logic    load;
    logic    timer;
    mul_op_e mul_op;
    logic    big_start;
    logic    big_sel;
    logic    lhs_take;
    logic    fin;
    fin_e    fin_kind;
  } cmd_t;

  typedef struct packed {
    logic gate_on;
    logic run;
    logic viewer;
    logic enclosed;
    logic p_pos;
    logic big_done;
    logic ge;
    logic out_full;
  } sts_t;

  localparam logic [1:0] CFG_GATE     = 2'd0;
  localparam logic [1:0] CFG_INTERVAL = 2'd1;
  localparam logic [1:0] CFG_GRACE    = 2'd2;
  localparam logic [1:0] CFG_HALF     = 2'd3;

  localparam logic [23:0] INTERVAL_RST = 24'd100000;
  localparam logic [23:0] GRACE_RST    = 24'd500000;
  localparam logic [6:0]  HALF_RST     = 7'd60;
  localparam logic [6:0]  HALF_MIN     = 7'd1;
  localparam logic [6:0]  HALF_MAX     = 7'd89;
  localparam logic [6:0]  RIGHT_ANGLE  = 7'd90;

  // cos(k deg) in q1.14, k = 0..90
  localparam logic [14:0] COS_Q14 [0:90] = '{
    15'd16384, 15'd16382, 15'd16374, 15'd16362, 15'd16344, 15'd16322, 15'd16294,
    15'd16262, 15'd16225, 15'd16182, 15'd16135, 15'd16083, 15'd16026, 15'd15964,
    15'd15897, 15'd15826, 15'd15749, 15'd15668, 15'd15582, 15'd15491, 15'd15396,
    15'd15296, 15'd15191, 15'd15082, 15'd14968, 15'd14849, 15'd14726, 15'd14598,
    15'd14466, 15'd14330, 15'd14189, 15'd14044, 15'd13894, 15'd13741, 15'd13583,
    15'd13421, 15'd13255, 15'd13085, 15'd12911, 15'd12733, 15'd12551, 15'd12365,
    15'd12176, 15'd11982, 15'd11786, 15'd11585, 15'd11381, 15'd11174, 15'd10963,
    15'd10749, 15'd10531, 15'd10311, 15'd10087, 15'd9860,  15'd9630,  15'd9397,
    15'd9162,  15'd8923,  15'd8682,  15'd8438,  15'd8192,  15'd7943,  15'd7692,
    15'd7438,  15'd7182,  15'd6924,  15'd6664,  15'd6402,  15'd6138,  15'd5872,
    15'd5604,  15'd5334,  15'd5063,  15'd4790,  15'd4516,  15'd4240,  15'd3964,
    15'd3686,  15'd3406,  15'd3126,  15'd2845,  15'd2563,  15'd2280,  15'd1997,
    15'd1713,  15'd1428,  15'd1143,  15'd857,   15'd572,   15'd286,   15'd0
  };

endpackage

// ===== hw/rtl/vcg_ctrl.sv =====
// controller state machine sequencing one item through the datapath
module vcg_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  vcg_pkg::sts_t sts_i,
  output vcg_pkg::cmd_t cmd_o
);
  import vcg_pkg::*;

  state_e  state_q, state_d;
  mul_op_e op_q, op_d;
  fin_e    kind_q, kind_d;
  mul_op_e op_next;

  always_comb begin
    unique case (op_q)
      OP_SQX:  op_next = OP_SQY;
      OP_SQY:  op_next = OP_SQZ;
      OP_SQZ:  op_next = OP_SQR;
      OP_SQR:  op_next = OP_DOTX;
      OP_DOTX: op_next = OP_DOTY;
      OP_DOTY: op_next = OP_DOTZ;
      OP_DOTZ: op_next = OP_SR;
      OP_SR:   op_next = OP_CC;
      default: op_next = OP_NONE;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    kind_d  = kind_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_TIMER;
      end
      ST_TIMER: begin
        if (!sts_i.gate_on) begin
          kind_d  = FIN_OFF;
          state_d = ST_FIN;
        end else if (!sts_i.run) begin
          kind_d  = FIN_NOCHECK;
          state_d = ST_FIN;
        end else if (!sts_i.viewer) begin
          kind_d  = FIN_PASS;
          state_d = ST_FIN;
        end else begin
          op_d    = OP_SQX;
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        if (op_q == OP_CC) state_d = ST_MAC_END;
        op_d = op_next;
      end
      ST_MAC_END: state_d = ST_TEST;
      ST_TEST: begin
        if (sts_i.enclosed) begin
          kind_d  = FIN_PASS;
          state_d = ST_FIN;
        end else if (!sts_i.p_pos) begin
          kind_d  = FIN_FAIL;
          state_d = ST_FIN;
        end else begin
          state_d = ST_GO_P;
        end
      end
      ST_GO_P: state_d = ST_WAIT_P;
      ST_WAIT_P: begin
        if (sts_i.big_done) state_d = ST_GO_Q;
      end
      ST_GO_Q: state_d = ST_WAIT_Q;
      ST_WAIT_Q: begin
        if (sts_i.big_done) begin
          kind_d  = sts_i.ge ? FIN_PASS : FIN_FAIL;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!sts_i.out_full) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o          = '0;
    cmd_o.mul_op   = OP_NONE;
    cmd_o.fin_kind = kind_q;
    in_ready_o     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_TIMER:   cmd_o.timer = 1'b1;
      ST_MAC:     cmd_o.mul_op = op_q;
      ST_GO_P: begin
        cmd_o.big_start = 1'b1;
        cmd_o.big_sel   = 1'b0;
      end
      ST_WAIT_P:  cmd_o.lhs_take = sts_i.big_done;
      ST_GO_Q: begin
        cmd_o.big_start = 1'b1;
        cmd_o.big_sel   = 1'b1;
      end
      ST_FIN:     cmd_o.fin = !sts_i.out_full;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_NONE;
      kind_q  <= FIN_OFF;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      kind_q  <= kind_d;
    end
  end

endmodule

// ===== hw/rtl/vcg_imul.sv =====
// iterative unsigned multiplier, one byte of the multiplier per cycle
module vcg_imul #(
  parameter int AW = 50,
  parameter int BW = 42
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [AW-1:0]                  a_i,
  input  logic [BW-1:0]                  b_i,
  output logic                           done_o,
  output logic [AW+8*((BW+7)/8)-1:0]     prod_o
);
  localparam int NDIG = (BW + 7) / 8;
  localparam int BPW  = NDIG * 8;
  localparam int PRW  = AW + BPW;
  localparam int CW   = $clog2(NDIG);

  logic [AW-1:0]  a_q;
  logic [BPW-1:0] b_q;
  logic [PRW-1:0] acc_q;
  logic [CW-1:0]  cnt_q;
  logic           busy_q, done_q;
  logic [AW+7:0]  part;

  assign part   = a_q * b_q[BPW-1 -: 8];
  assign done_o = done_q;
  assign prod_o = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(NDIG - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // msb-first shift and add
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= BPW'(b_i);
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= {acc_q[PRW-9:0], 8'b0} + PRW'(part);
      b_q   <= {b_q[BPW-9:0], 8'b0};
    end
  end

endmodule

// ===== hw/rtl/vcg_dp.sv =====
// datapath: config, timers, shared multiply-accumulate and cone compare
module vcg_dp #(
  parameter int PB = 24,
  parameter int TB = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [23:0]          cfg_wdata_i,
  input  logic [19:0]          delta_us_i,
  input  logic signed [PB-1:0] sphere_x_i,
  input  logic signed [PB-1:0] sphere_y_i,
  input  logic signed [PB-1:0] sphere_z_i,
  input  logic [PB-2:0]        sphere_radius_i,
  input  logic signed [PB-1:0] eye_x_i,
  input  logic signed [PB-1:0] eye_y_i,
  input  logic signed [PB-1:0] eye_z_i,
  input  logic signed [15:0]   look_x_i,
  input  logic signed [15:0]   look_y_i,
  input  logic signed [15:0]   look_z_i,
  input  logic                 viewer_present_i,
  input  vcg_pkg::cmd_t        cmd_i,
  output vcg_pkg::sts_t        sts_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           out_data_o
);
  import vcg_pkg::*;

  localparam int DW  = PB + 1;
  localparam int MW  = PB + 2;
  localparam int D2W = 2 * PB + 2;
  localparam int R2W = 2 * PB - 2;
  localparam int PW  = PB + 19;
  localparam int BW  = PB + 18;
  localparam int PRW = D2W + 8 * ((BW + 7) / 8);
  localparam int TBC = (TB > 24) ? TB : 24;
  localparam logic [TB-1:0] TMAX = '1;

  // config
  logic        gate_q;
  logic [23:0] interval_q, grace_q;
  logic [6:0]  half_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_q     <= 1'b1;
      interval_q <= INTERVAL_RST;
      grace_q    <= GRACE_RST;
      half_q     <= HALF_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_GATE:     gate_q     <= cfg_wdata_i[0];
        CFG_INTERVAL: interval_q <= cfg_wdata_i;
        CFG_GRACE:    grace_q    <= cfg_wdata_i;
        CFG_HALF:     half_q     <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  // item registers
  logic [19:0]          delta_q;
  logic signed [DW-1:0] dx_q, dy_q, dz_q;
  logic [PB-2:0]        r_q;
  logic signed [15:0]   lx_q, ly_q, lz_q;
  logic                 viewer_q;
  logic [14:0]          c_q, s_q;
  logic [6:0]           h;

  always_comb begin
    h = half_q;
    if (h < HALF_MIN) h = HALF_MIN;
    if (h > HALF_MAX) h = HALF_MAX;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      delta_q  <= delta_us_i;
      dx_q     <= DW'(sphere_x_i) - DW'(eye_x_i);
      dy_q     <= DW'(sphere_y_i) - DW'(eye_y_i);
      dz_q     <= DW'(sphere_z_i) - DW'(eye_z_i);
      r_q      <= sphere_radius_i;
      lx_q     <= look_x_i;
      ly_q     <= look_y_i;
      lz_q     <= look_z_i;
      viewer_q <= viewer_present_i;
      c_q      <= COS_Q14[h];
      s_q      <= COS_Q14[7'(RIGHT_ANGLE - h)];
    end
  end

  // shared multiplier, the registered product is accumulated in the next cycle
  logic signed [MW-1:0]   ma, mb;
  logic signed [2*MW-1:0] prod_q;
  mul_op_e                acc_op_q;
  logic [D2W-1:0]         d2_q;
  logic [R2W-1:0]         r2_q;
  logic signed [PW-1:0]   p_q;
  logic [27:0]            c2_q;

  always_comb begin
    case (cmd_i.mul_op)
      OP_SQX:  begin ma = MW'(dx_q); mb = MW'(dx_q); end
      OP_SQY:  begin ma = MW'(dy_q); mb = MW'(dy_q); end
      OP_SQZ:  begin ma = MW'(dz_q); mb = MW'(dz_q); end
      OP_SQR:  begin ma = $signed({3'b0, r_q}); mb = $signed({3'b0, r_q}); end
      OP_DOTX: begin ma = MW'(lx_q); mb = MW'(dx_q); end
      OP_DOTY: begin ma = MW'(ly_q); mb = MW'(dy_q); end
      OP_DOTZ: begin ma = MW'(lz_q); mb = MW'(dz_q); end
      OP_SR:   begin ma = $signed(MW'(s_q)); mb = $signed({3'b0, r_q}); end
      OP_CC:   begin ma = $signed(MW'(c_q)); mb = $signed(MW'(c_q)); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) acc_op_q <= OP_NONE;
    else         acc_op_q <= cmd_i.mul_op;
  end

  always_ff @(posedge clk_i) begin
    prod_q <= ma * mb;
    if (cmd_i.load) begin
      d2_q <= '0;
      p_q  <= '0;
    end else begin
      case (acc_op_q)
        OP_SQX, OP_SQY, OP_SQZ:    d2_q <= d2_q + prod_q[D2W-1:0];
        OP_SQR:                    r2_q <= prod_q[R2W-1:0];
        OP_DOTX, OP_DOTY, OP_DOTZ,
        OP_SR:                     p_q  <= p_q + prod_q[PW-1:0];
        OP_CC:                     c2_q <= prod_q[27:0];
        default: ;
      endcase
    end
  end

  // wide products p*p and (d2 - r2)*c2
  logic [D2W-1:0] big_a;
  logic [BW-1:0]  big_b;
  logic [PRW-1:0] big_prod, lhs_q;
  logic           big_done;

  always_comb begin
    if (cmd_i.big_sel) begin
      big_a = d2_q - D2W'(r2_q);
      big_b = BW'(c2_q);
    end else begin
      big_a = D2W'(p_q[BW-1:0]);
      big_b = p_q[BW-1:0];
    end
  end

  vcg_imul #(.AW(D2W), .BW(BW)) u_imul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.big_start),
    .a_i     (big_a),
    .b_i     (big_b),
    .done_o  (big_done),
    .prod_o  (big_prod)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.lhs_take) lhs_q <= big_prod;
  end

  // timers
  logic [TB-1:0] since_q, outside_q, elapsed_q;
  logic          in_view_q;
  logic [TB:0]   since_sum, out_sum;
  logic [TB-1:0] since_new, out_new, add_t;
  logic          run;

  assign since_sum = {1'b0, since_q} + (TB + 1)'(delta_q);
  assign since_new = since_sum[TB] ? TMAX : since_sum[TB-1:0];
  assign run       = (interval_q == '0) || (TBC'(since_new) >= TBC'(interval_q));
  assign add_t     = (TB'(delta_q) > elapsed_q) ? TB'(delta_q) : elapsed_q;
  assign out_sum   = {1'b0, outside_q} + {1'b0, add_t};
  assign out_new   = out_sum[TB] ? TMAX : out_sum[TB-1:0];

  logic out_valid_q;
  logic [2:0] out_q;
  logic fail_draw;

  assign fail_draw = TBC'(out_new) < TBC'(grace_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      since_q     <= TB'(INTERVAL_RST);
      outside_q   <= '0;
      in_view_q   <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.timer) begin
        if (!gate_q) begin
          since_q   <= '0;
          outside_q <= '0;
          in_view_q <= 1'b1;
        end else begin
          since_q <= run ? '0 : since_new;
        end
      end
      if (cmd_i.fin) begin
        out_valid_q <= 1'b1;
        if (cmd_i.fin_kind == FIN_PASS) begin
          in_view_q <= 1'b1;
          outside_q <= '0;
        end else if (cmd_i.fin_kind == FIN_FAIL) begin
          outside_q <= out_new;
          in_view_q <= fail_draw;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output fields: draw_enabled, check_ran, seen_now
  always_ff @(posedge clk_i) begin
    if (cmd_i.timer) elapsed_q <= since_new;
    if (cmd_i.fin) begin
      unique case (cmd_i.fin_kind)
        FIN_OFF:     out_q <= 3'b001;
        FIN_NOCHECK: out_q <= {2'b00, in_view_q};
        FIN_PASS:    out_q <= 3'b111;
        FIN_FAIL:    out_q <= {2'b01, fail_draw};
        default:     out_q <= 3'b000;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.gate_on  = gate_q;
  assign sts_o.run      = run;
  assign sts_o.viewer   = viewer_q;
  assign sts_o.enclosed = D2W'(r2_q) >= d2_q;
  assign sts_o.p_pos    = !p_q[PW-1] && (p_q != '0);
  assign sts_o.big_done = big_done;
  assign sts_o.ge       = lhs_q >= big_prod;
  assign sts_o.out_full = out_valid_q && !out_ready_i;

endmodule

// ===== hw/rtl/view_cone_visibility_gate_unit.sv =====
// top level of the view cone visibility gate
// One item per frame tick enters on the s_axis channel: tdata carries the
// elapsed time, sphere centre and radius, eye position and look direction;
// tuser carries the viewer present flag. One result item leaves on m_axis
// per input item with draw_enabled, check_ran and seen_now.
// Configuration is a plain write port (enable, index, data), used while idle.
// An item ends after the timer step when no check runs or no viewer is
// present, and after the multiply steps when the viewer is inside the sphere
// or the centre lies behind the viewer. Otherwise nine steps of the shared
// signed multiplier build the squared distance and dot product, then the
// byte-serial multiplier forms the two wide cone products one after the
// other. One item is worked at a time.
// Results sit in an output register; a new item is taken while a result
// waits, and a finished item holds in the controller until the output
// register frees up, so a stalled receiver loses nothing.
// Reset loads the register defaults, the check timer with the default
// interval and marks the widget in view; no result is pending after reset.
module view_cone_visibility_gate_unit #(
  parameter int POS_BITS  = 24,
  parameter int TIME_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // delta_us, sphere_x, sphere_y, sphere_z, sphere_radius, eye_x, eye_y, eye_z,
  // look_x, look_y, look_z
  input  logic [((7*POS_BITS+67+7)/8)*8-1:0] s_axis_tdata,
  // viewer_present
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // draw_enabled, check_ran, seen_now
  output logic [7:0]  m_axis_tdata
);
  import vcg_pkg::*;

  localparam int PB   = POS_BITS;
  localparam int O_SX = 20;
  localparam int O_SY = O_SX + PB;
  localparam int O_SZ = O_SY + PB;
  localparam int O_R  = O_SZ + PB;
  localparam int O_EX = O_R + PB - 1;
  localparam int O_EY = O_EX + PB;
  localparam int O_EZ = O_EY + PB;
  localparam int O_LX = O_EZ + PB;
  localparam int O_LY = O_LX + 16;
  localparam int O_LZ = O_LY + 16;

  cmd_t       cmd;
  sts_t       sts;
  logic [2:0] out_data;

  vcg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vcg_dp #(.PB(POS_BITS), .TB(TIME_BITS)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .delta_us_i       (s_axis_tdata[19:0]),
    .sphere_x_i       ($signed(s_axis_tdata[O_SX +: PB])),
    .sphere_y_i       ($signed(s_axis_tdata[O_SY +: PB])),
    .sphere_z_i       ($signed(s_axis_tdata[O_SZ +: PB])),
    .sphere_radius_i  (s_axis_tdata[O_R +: PB-1]),
    .eye_x_i          ($signed(s_axis_tdata[O_EX +: PB])),
    .eye_y_i          ($signed(s_axis_tdata[O_EY +: PB])),
    .eye_z_i          ($signed(s_axis_tdata[O_EZ +: PB])),
    .look_x_i         ($signed(s_axis_tdata[O_LX +: 16])),
    .look_y_i         ($signed(s_axis_tdata[O_LY +: 16])),
    .look_z_i         ($signed(s_axis_tdata[O_LZ +: 16])),
    .viewer_present_i (s_axis_tuser),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_data_o       (out_data)
  );

  assign m_axis_tdata = {5'b0, out_data};

`include "view_cone_visibility_gate_unit_assert.svh"

  // one item in flight: no accept right after an accept
  `VCG_ASSERT(a_one_item, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
  // a seen result implies a check ran
  `VCG_ASSERT_ALWAYS(a_seen_ran, clk_i, m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1])
  // a passed check always allows drawing
  `VCG_ASSERT(a_seen_draw, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[0])

endmodule
